[rtl/rte_pkg.sv]
// Package with the transaction types and constants of the relocation table encoder.
package rte_pkg;

  // Distance that one skip code stands for.
  localparam int unsigned SkipStep = 254;

  // Widths of the distance bookkeeping.
  localparam int unsigned DistW = 16;
  localparam int unsigned SkipW = 9;
  localparam int unsigned CodeW = 8;
  localparam int unsigned ZpW   = 9;

  // Values of the pass selection register.
  localparam logic PassZeroPage = 1'b0;
  localparam logic PassHighByte = 1'b1;

  // Input transaction: one byte pair of the two builds.
  typedef struct packed {
    logic [7:0] byte_first;
    logic [7:0] byte_second;
    logic       last;
  } rte_in_t;

  // Output transaction: one encoded result per byte pair.
  typedef struct packed {
    logic [7:0]       patched_byte;
    logic             is_reloc;
    logic [SkipW-1:0] skip_count;
    logic [CodeW-1:0] offset_code;
    logic             end_marker;
    logic             bad;
    logic [ZpW-1:0]   zero_page_limit;
  } rte_out_t;

endpackage

[rtl/relocation_table_encoder_top.sv]
// Relocation table encoder: classifies byte pairs and encodes relocation distances.
//
// Usage: each input transaction carries one byte of the base build, the byte at
// the same place in the shifted build and a flag marking the last byte of the
// range. The block returns exactly one output transaction per input: the
// rebased byte, whether it is a relocation of the selected kind, the distance to
// the previous relocation as a count of skip codes plus an offset code, the end
// marker, a bad-pair flag and the running zero-page limit.
// Both channels use valid and stall. An accepted result goes to the output
// register, or to the skid register while a result is stalled. One byte pair is
// taken every cycle while the input is not stalled. The distance is kept by an
// incremental counter (skip and offset digits) updated at each acceptance, so no
// division is needed. A skid register lets one more transaction in while a result
// is stalled; the input stalls only while the skid register is occupied.
// The user writes the pass kind register (cfg_we_i/cfg_wdata_i) while idle; the
// block does not enforce this. Reset clears the distance counters, the zero-page
// limit, pass kind and all valid flags; it is ready in the first cycle after reset.
module relocation_table_encoder_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  rte_pkg::rte_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output rte_pkg::rte_out_t out_data_o
);
  import rte_pkg::*;

  logic             pass_kind_q;
  logic [DistW-1:0] dist_q, dist_d;
  logic [SkipW-1:0] skip_q, skip_d;
  logic [CodeW-1:0] code_q, code_d;
  logic [ZpW-1:0]   zp_max_q, zp_max_d;

  logic             out_valid_q, out_valid_d;
  rte_out_t         out_data_q;
  logic             skid_valid_q, skid_valid_d;
  rte_out_t         skid_data_q;

  logic             in_acc;
  logic             out_take;
  logic             out_load;
  logic [8:0]       b1_ext, b2_ext, b1_plus1, b1_plus2;
  logic             is_equal, is_hi_ref, is_zp_ref, is_reloc, is_bad;
  rte_out_t         result;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_take = out_valid_q && !out_stall_i;
  assign out_load = out_take || !out_valid_q;

  // Pass selection register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pass_kind_q <= PassZeroPage;
    end else if (cfg_we_i) begin
      pass_kind_q <= cfg_wdata_i;
    end
  end

  // Classification by the plain difference of the two bytes.
  always_comb begin
    b1_ext    = {1'b0, in_data_i.byte_first};
    b2_ext    = {1'b0, in_data_i.byte_second};
    b1_plus1  = b1_ext + 9'd1;
    b1_plus2  = b1_ext + 9'd2;
    is_equal  = (b2_ext == b1_ext);
    is_hi_ref = (b2_ext == b1_plus1);
    is_zp_ref = (b2_ext == b1_plus2);
    is_bad    = !is_equal && !is_hi_ref && !is_zp_ref;
    is_reloc  = (pass_kind_q == PassHighByte) ? is_hi_ref : is_zp_ref;
  end

  // Result of the current pair and next state of the distance counters.
  always_comb begin
    dist_d   = dist_q;
    skip_d   = skip_q;
    code_d   = code_q;
    zp_max_d = zp_max_q;

    result.patched_byte    = in_data_i.byte_first;
    result.is_reloc        = is_reloc;
    result.skip_count      = '0;
    result.offset_code     = '0;
    result.end_marker      = in_data_i.last;
    result.bad             = is_bad;

    if (is_reloc) begin
      result.skip_count  = skip_q;
      result.offset_code = code_q;
      if (pass_kind_q == PassHighByte) begin
        result.patched_byte = in_data_i.byte_first - 8'd1;
      end else begin
        result.patched_byte = in_data_i.byte_first - 8'd2;
        if (zp_max_q < b1_plus1) begin
          zp_max_d = b1_plus1;
        end
      end
    end
    result.zero_page_limit = zp_max_d;

    // The counters hold the distance from the previous relocation to the next byte.
    if (in_data_i.last) begin
      dist_d = '0;
      skip_d = '0;
      code_d = '0;
    end else if (is_reloc) begin
      dist_d = DistW'(1);
      skip_d = '0;
      code_d = CodeW'(1);
    end else if (dist_q == '1) begin
      dist_d = '0;
      skip_d = '0;
      code_d = '0;
    end else begin
      dist_d = dist_q + DistW'(1);
      if (code_q == CodeW'(SkipStep)) begin
        skip_d = skip_q + SkipW'(1);
        code_d = CodeW'(1);
      end else begin
        code_d = code_q + CodeW'(1);
      end
    end
  end

  // State update on every accepted transaction.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dist_q   <= '0;
      skip_q   <= '0;
      code_q   <= '0;
      zp_max_q <= '0;
    end else if (in_acc) begin
      dist_q   <= dist_d;
      skip_q   <= skip_d;
      code_q   <= code_d;
      zp_max_q <= zp_max_d;
    end
  end

  // Output register with a skid register behind it.
  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_load) begin
      out_valid_d  = skid_valid_q || in_acc;
      skid_valid_d = 1'b0;
    end else if (in_acc) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= skid_valid_q ? skid_data_q : result;
    end
    if (in_acc && !out_load) begin
      skid_data_q <= result;
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[rtl/rte_checker.sv]
// Port-level checker for the relocation table encoder and its bind statement.
module rte_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input rte_pkg::rte_out_t out_data_o
);
  import rte_pkg::*;

  // A stalled result stays valid and unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed or dropped");

  // A transaction accepted while the output is empty appears in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> out_valid_o)
    else $error("accepted transaction did not reach the output");

  // The zero-page limit never falls from one result to the next.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && $past(out_valid_o && !out_stall_i) |->
      out_data_o.zero_page_limit >= $past(out_data_o.zero_page_limit))
    else $error("zero-page limit decreased");

  // Skip codes only precede a non-zero offset of a relocation.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.skip_count != '0 |->
      out_data_o.is_reloc && out_data_o.offset_code != '0)
    else $error("skip codes without a valid relocation offset");

endmodule

bind relocation_table_encoder_top rte_checker u_rte_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

[tb/sv/tb_relocation_table_encoder_top.sv]
// Self-checking testbench for the relocation table encoder with directed and random byte pairs.
module tb_relocation_table_encoder_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rte_pkg::*;

  // Rebase amounts of the two kinds of reference.
  localparam int unsigned ZpShift = 2;
  localparam int unsigned HiShift = 1;
  // Size of the random part.
  localparam int unsigned RandomPairs = 1320;
  // Distances between references that sit around the skip code boundaries.
  localparam int unsigned RefGaps [10] = '{1, 2, 253, 254, 255, 256, 508, 509, 510, 763};

  typedef enum logic [1:0] {PairSame, PairZp, PairHigh, PairBad} pair_kind_e;

  typedef struct {
    rte_in_t     pair;
    int unsigned idle_after;
  } queued_pair_t;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     cfg_we_i    = 1'b0;
  logic     cfg_wdata_i = 1'b0;
  logic     in_valid_i  = 1'b0;
  logic     in_stall_o;
  rte_in_t  in_data_i   = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  rte_out_t out_data_o;

  // Pairs waiting to be driven and encodings waiting to come out.
  queued_pair_t pair_fifo[$];
  queued_pair_t next_pair;
  rte_out_t     expected_codes[$];
  rte_out_t     want;

  // Predicted state of the encoder.
  logic        pass_sel     = PassZeroPage;
  logic [15:0] pos_cnt      = '0;
  logic [15:0] last_ref_pos = '0;
  logic [8:0]  zp_lim       = '0;
  logic        err_seen     = 1'b0;

  // Idling controls and bookkeeping.
  bit          tx_idle_on  = 1'b1;
  bit          rx_stall_on = 1'b1;
  int unsigned idle_left   = 0;
  int unsigned stall_left  = 0;
  int unsigned pairs_queued = 0;
  int unsigned mismatches  = 0;
  int unsigned results_seen = 0;
  int unsigned relocs_seen = 0;
  int unsigned bads_seen   = 0;
  int unsigned ends_seen   = 0;
  int unsigned max_skips   = 0;
  int unsigned cfg_writes  = 0;

  relocation_table_encoder_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  // Length of a pause: mostly none or short, now and then long.
  function automatic int unsigned pick_pause();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Encodes one byte pair against the predicted state and advances that state.
  function automatic rte_out_t encode_pair(rte_in_t pair);
    rte_out_t    res;
    int unsigned first, second, shift, gap, skips;
    logic [15:0] span;
    res = '0;
    first = pair.byte_first;
    second = pair.byte_second;
    shift = (pass_sel == PassHighByte) ? HiShift : ZpShift;
    res.patched_byte = pair.byte_first;
    res.end_marker = pair.last;
    if (second != first && second != first + HiShift && second != first + ZpShift) begin
      res.bad = 1'b1;
      err_seen = 1'b1;
    end else if (second == first + shift) begin
      span = pos_cnt - last_ref_pos;
      gap = span;
      skips = 0;
      if (gap > SkipStep) skips = (gap - 1) / SkipStep;
      res.is_reloc = 1'b1;
      res.skip_count = SkipW'(skips);
      res.offset_code = CodeW'(gap - skips * SkipStep);
      res.patched_byte = pair.byte_first - 8'(shift);
      last_ref_pos = pos_cnt;
      if (shift == ZpShift && zp_lim < first + 1) zp_lim = ZpW'(first + 1);
    end
    pos_cnt = pos_cnt + 16'd1;
    if (pair.last) begin
      pos_cnt = '0;
      last_ref_pos = '0;
    end
    res.zero_page_limit = zp_lim;
    return res;
  endfunction

  // Reports one field that differs from its prediction.
  function automatic void check_field(string field, logic [15:0] exp_val, logic [15:0] got);
    if (exp_val !== got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp_val, got);
      mismatches++;
    end
  endfunction

  // Driver: presents queued pairs and predicts each accepted transaction.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      idle_left <= 0;
    end else begin
      if (in_valid_i && !in_stall_o) expected_codes.push_back(encode_pair(in_data_i));
      if (!in_valid_i || !in_stall_o) begin
        if (idle_left != 0) begin
          in_valid_i <= 1'b0;
          idle_left <= idle_left - 1;
        end else if (pair_fifo.size() != 0) begin
          next_pair = pair_fifo.pop_front();
          in_data_i <= next_pair.pair;
          idle_left <= next_pair.idle_after;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result and stalls the output at random.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_codes.size() == 0) begin
          $display("%0t: result with no byte pair outstanding: expected none, actual %p",
                   $time, out_data_o);
          mismatches++;
        end else begin
          want = expected_codes.pop_front();
          check_field("patched_byte", want.patched_byte, out_data_o.patched_byte);
          check_field("is_reloc", want.is_reloc, out_data_o.is_reloc);
          check_field("skip_count", want.skip_count, out_data_o.skip_count);
          check_field("offset_code", want.offset_code, out_data_o.offset_code);
          check_field("end_marker", want.end_marker, out_data_o.end_marker);
          check_field("bad", want.bad, out_data_o.bad);
          check_field("zero_page_limit", want.zero_page_limit, out_data_o.zero_page_limit);
          results_seen++;
          relocs_seen += want.is_reloc;
          bads_seen += want.bad;
          ends_seen += want.end_marker;
          if (want.skip_count > max_skips) max_skips = want.skip_count;
        end
      end
      if (stall_left != 0) begin
        out_stall_i <= 1'b1;
        stall_left <= stall_left - 1;
      end else if (rx_stall_on && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        stall_left <= pick_pause();
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Waits until no transaction is queued, in flight or outstanding.
  task automatic drain();
    do @(negedge clk_i);
    while (pair_fifo.size() != 0 || in_valid_i || expected_codes.size() != 0);
  endtask

  // Writes the pass kind register while the encoder is idle.
  task automatic set_pass(logic kind);
    drain();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= kind;
    pass_sel = kind;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    cfg_writes++;
  endtask

  task automatic queue_pair(logic [7:0] first, logic [7:0] second, logic last);
    queued_pair_t entry;
    entry.pair.byte_first = first;
    entry.pair.byte_second = second;
    entry.pair.last = last;
    entry.idle_after = tx_idle_on ? pick_pause() : 0;
    pair_fifo.push_back(entry);
    pairs_queued++;
  endtask

  // Builds random bytes whose difference matches the requested kind.
  task automatic queue_kind(pair_kind_e kind, logic last);
    logic [7:0] first, second;
    first = 8'($urandom_range(0, 255));
    second = first;
    case (kind)
      PairZp: begin
        first = 8'($urandom_range(0, 253));
        second = first + 8'(ZpShift);
      end
      PairHigh: begin
        first = 8'($urandom_range(0, 254));
        second = first + 8'(HiShift);
      end
      PairBad: begin
        second = 8'($urandom_range(0, 255));
        while ((int'(second) - int'(first)) inside {0, 1, 2}) second = 8'($urandom_range(0, 255));
      end
      default: ;
    endcase
    queue_pair(first, second, last);
  endtask

  function automatic pair_kind_e sel_kind();
    return (pass_sel == PassHighByte) ? PairHigh : PairZp;
  endfunction

  // Filler that the current pass never encodes.
  function automatic pair_kind_e filler_kind();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 80) return PairSame;
    if (roll < 90) return (pass_sel == PassHighByte) ? PairZp : PairHigh;
    return PairBad;
  endfunction

  // A range of mixed pairs, optionally closed by an end marker.
  task automatic send_mixed_range(int unsigned len, int unsigned ref_pct, int unsigned bad_pct,
                                  bit close);
    int unsigned roll;
    pair_kind_e  kind;
    for (int unsigned i = 0; i < len; i++) begin
      roll = $urandom_range(0, 99);
      if (roll < ref_pct) kind = ($urandom_range(0, 1) != 0) ? PairZp : PairHigh;
      else if (roll < ref_pct + bad_pct) kind = PairBad;
      else kind = PairSame;
      queue_kind(kind, (close && i == len - 1) || $urandom_range(0, 63) == 0);
    end
  endtask

  // Two references placed at a distance around the skip code boundaries.
  task automatic send_spaced_range();
    int unsigned span;
    queue_kind(sel_kind(), 1'b0);
    span = RefGaps[$urandom_range(0, 9)];
    repeat (span - 1) queue_kind(filler_kind(), 1'b0);
    queue_kind(sel_kind(), 1'b0);
    queue_kind(filler_kind(), 1'b1);
  endtask

  // Stimulus sequence.
  initial begin
    int unsigned target, roll, remaining;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Zero-page pass: zero distance, rebase underflow, field extremes, bad pairs, end.
    set_pass(PassZeroPage);
    queue_pair(8'd0, 8'd2, 1'b0);
    queue_pair(8'd253, 8'd255, 1'b0);
    queue_pair(8'd255, 8'd255, 1'b0);
    queue_pair(8'd0, 8'd0, 1'b0);
    queue_pair(8'd255, 8'd0, 1'b0);
    queue_pair(8'd254, 8'd0, 1'b0);
    queue_pair(8'd0, 8'd255, 1'b0);
    queue_pair(8'd0, 8'd1, 1'b0);
    queue_pair(8'd10, 8'd12, 1'b1);
    queue_pair(8'd40, 8'd42, 1'b0);
    // Hold the sender until every result is back.
    drain();

    // High-byte pass: underflow, top byte, zero-page pair ignored, reference on the last item.
    set_pass(PassHighByte);
    queue_pair(8'd0, 8'd1, 1'b0);
    queue_pair(8'd254, 8'd255, 1'b0);
    queue_pair(8'd5, 8'd7, 1'b0);
    queue_pair(8'd255, 8'd254, 1'b0);
    queue_pair(8'd128, 8'd128, 1'b1);
    queue_pair(8'd77, 8'd78, 1'b1);

    // Random phases, each with its own pass kind and idling mode.
    target = pairs_queued + RandomPairs;
    while (pairs_queued < target) begin
      set_pass(1'($urandom_range(0, 1)));
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_stall_on = tx_idle_on;
      repeat ($urandom_range(2, 6)) begin
        if (pairs_queued >= target) break;
        remaining = target - pairs_queued;
        roll = $urandom_range(0, 99);
        // Long ranges are only started while they still fit in the budget.
        if (roll < 60) send_mixed_range($urandom_range(1, 40), 35, 5, 1'b1);
        else if (roll < 70 && remaining >= 800) send_mixed_range($urandom_range(200, 600), 1, 1, 1'b1);
        else if (roll < 80 && remaining >= 800) send_spaced_range();
        else send_mixed_range($urandom_range(1, 30), 20, 40, 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 9) == 0) drain();
      end
    end

    // Short closing phase back on the zero-page pass, with idling.
    set_pass(PassZeroPage);
    tx_idle_on = 1'b1;
    rx_stall_on = 1'b1;
    send_mixed_range(60, 35, 5, 1'b1);
    drain();
    repeat (10) @(negedge clk_i);

    $display("Checked %0d results: %0d relocations, %0d bad pairs, %0d range ends, skips up to %0d.",
             results_seen, relocs_seen, bads_seen, ends_seen, max_skips);
    $display("Pass kind written %0d times; bad pair seen: %0b.", cfg_writes, err_seen);
    if (mismatches == 0 && expected_codes.size() == 0) begin
      $display("relocation_table_encoder_top test passed");
    end else begin
      $display("relocation_table_encoder_top test failed");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #30_000_000;
    $display("relocation_table_encoder_top test failed");
    $finish;
  end

endmodule
